// ===== design/pjs_pkg.sv =====
// Shared definitions for the periodic job scheduler: field widths, mode and
// error codes, flag bit positions, and the controller/datapath command and status structs.
// No dependencies.
package pjs_pkg;

  localparam int MAX_JOBS_DEFAULT = 16;

  localparam int TIME_W   = 32;
  localparam int ID_W     = 4;
  localparam int MODE_W   = 2;
  localparam int ERR_W    = 2;
  localparam int FLAG_W   = 3;

  localparam int S_TDATA_W = 72;
  localparam int S_TUSER_W = MODE_W;
  localparam int M_TDATA_W = 8;
  localparam int M_TUSER_W = 1 + ERR_W;

  localparam logic [MODE_W-1:0] MODE_REGISTER = 2'd0;
  localparam logic [MODE_W-1:0] MODE_UPDATE   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_PASS     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_COMPLETE = 2'd3;

  localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
  localparam logic [ERR_W-1:0] ERR_FULL  = 2'd1;
  localparam logic [ERR_W-1:0] ERR_INDEX = 2'd2;

  localparam int FLAG_RUN   = 0;
  localparam int FLAG_STALL = 1;
  localparam int FLAG_PRIO  = 2;

  typedef struct packed {
    logic capture;
    logic reg_write;
    logic full_err;
    logic idx_err;
    logic upd_write;
    logic cpl_now;
    logic cpl_rd;
    logic cpl_add;
    logic scan_clr;
    logic scan_rd;
    logic scan_eval;
    logic none_due;
    logic pick_clr;
    logic list_rd;
    logic flag_rd;
    logic pick_eval;
    logic last_rd;
    logic remove;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic              table_full;
    logic              idx_ok;
    logic              stalled;
    logic              scan_end;
    logic              due_empty;
    logic              pick_end;
  } status_t;

endpackage

// ===== design/pjs_ctrl.sv =====
// Sequencer of the periodic job scheduler: owns the stream handshakes and
// issues datapath commands one step at a time. Depends on pjs_pkg.
module pjs_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  output logic             m_tvalid,
  input  logic             m_tready,
  input  pjs_pkg::status_t status,
  output pjs_pkg::cmd_t    cmd
);
  import pjs_pkg::*;

  typedef enum logic [3:0] {
    IDLE,
    DECODE,
    SCAN_RD,
    SCAN_EVAL,
    PICK_LIST,
    PICK_FLAG,
    PICK_EVAL,
    REMOVE,
    CPL_ADD,
    DONE
  } state_t;

  state_t state;
  logic   accept;
  logic   out_free;

  assign accept   = (state == IDLE) && s_tready && s_tvalid;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    cmd = '0;
    cmd.capture = accept;
    unique case (state)
      IDLE: begin
      end
      DECODE: begin
        unique case (status.mode)
          MODE_REGISTER: begin
            cmd.full_err  = status.table_full;
            cmd.reg_write = !status.table_full;
          end
          MODE_UPDATE: begin
            cmd.idx_err   = !status.idx_ok;
            cmd.upd_write = status.idx_ok;
          end
          MODE_PASS: begin
            cmd.scan_clr = 1'b1;
          end
          MODE_COMPLETE: begin
            cmd.idx_err = !status.idx_ok;
            cmd.cpl_now = status.idx_ok && status.stalled;
            cmd.cpl_rd  = status.idx_ok && !status.stalled;
          end
        endcase
      end
      SCAN_RD: begin
        cmd.scan_rd  = !status.scan_end;
        cmd.none_due = status.scan_end && status.due_empty;
        cmd.pick_clr = status.scan_end && !status.due_empty;
      end
      SCAN_EVAL: cmd.scan_eval = 1'b1;
      PICK_LIST: begin
        cmd.list_rd = !status.pick_end;
        cmd.last_rd = status.pick_end;
      end
      PICK_FLAG: cmd.flag_rd   = 1'b1;
      PICK_EVAL: cmd.pick_eval = 1'b1;
      REMOVE:    cmd.remove    = 1'b1;
      CPL_ADD:   cmd.cpl_add   = 1'b1;
      DONE:      cmd.out_load  = out_free;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= IDLE;
      s_tready <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            s_tready <= 1'b0;
            state    <= DECODE;
          end else begin
            s_tready <= 1'b1;
          end
        end
        DECODE: begin
          if (status.mode == MODE_PASS) begin
            state <= SCAN_RD;
          end else if (status.mode == MODE_COMPLETE && status.idx_ok && !status.stalled) begin
            state <= CPL_ADD;
          end else begin
            state <= DONE;
          end
        end
        SCAN_RD: begin
          if (!status.scan_end) begin
            state <= SCAN_EVAL;
          end else if (status.due_empty) begin
            state <= DONE;
          end else begin
            state <= PICK_LIST;
          end
        end
        SCAN_EVAL: state <= SCAN_RD;
        PICK_LIST: begin
          if (status.pick_end) begin
            state <= REMOVE;
          end else begin
            state <= PICK_FLAG;
          end
        end
        PICK_FLAG: state <= PICK_EVAL;
        PICK_EVAL: state <= PICK_LIST;
        REMOVE:    state <= DONE;
        CPL_ADD:   state <= DONE;
        DONE: begin
          if (out_free) begin
            m_tvalid <= 1'b1;
            s_tready <= 1'b1;
            state    <= IDLE;
          end
        end
      endcase
    end
  end

endmodule

// ===== design/pjs_datapath.sv =====
// Datapath of the periodic job scheduler: job tables, due list and due marks,
// scan and pick counters, and the result and output registers. Depends on pjs_pkg.
module pjs_datapath #(
  parameter int MAX_JOBS = pjs_pkg::MAX_JOBS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pjs_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic [pjs_pkg::S_TUSER_W-1:0] s_tuser,
  input  pjs_pkg::cmd_t                 cmd,
  output pjs_pkg::status_t              status,
  output logic [pjs_pkg::M_TDATA_W-1:0] m_tdata,
  output logic [pjs_pkg::M_TUSER_W-1:0] m_tuser
);
  import pjs_pkg::*;

  localparam int IW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int CW = $clog2(MAX_JOBS + 1);
  localparam int XW = (CW > ID_W) ? CW : ID_W;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_JOBS);

  // Captured input item.
  logic [MODE_W-1:0] in_mode;
  logic [TIME_W-1:0] in_now;
  logic [ID_W-1:0]   in_idx;
  logic [TIME_W-1:0] in_ival;
  logic [FLAG_W-1:0] in_flags;
  logic              in_stalled;

  // Job tables and due list.
  logic [TIME_W-1:0] ival_mem [MAX_JOBS];
  logic [TIME_W-1:0] last_mem [MAX_JOBS];
  logic [FLAG_W-1:0] flag_mem [MAX_JOBS];
  logic [IW-1:0]     list_mem [MAX_JOBS];

  logic [TIME_W-1:0] ival_q;
  logic [TIME_W-1:0] last_q;
  logic [FLAG_W-1:0] flag_q;
  logic [IW-1:0]     list_q;

  logic [CW-1:0]       job_count;
  logic [CW-1:0]       due_count;
  logic [MAX_JOBS-1:0] due_mark;
  logic [CW-1:0]       k;

  // Pick trackers.
  logic          prio_found;
  logic          ps_found;
  logic          norm_found;
  logic [IW-1:0] prio_idx, ps_idx, norm_idx;
  logic [IW-1:0] prio_job, ps_job, norm_job, first_job;
  logic [IW-1:0] sel_idx, sel_job;

  // Result waiting for the output register.
  logic [ID_W-1:0]  res_id;
  logic             res_valid;
  logic [ERR_W-1:0] res_err;

  logic [IW-1:0]     idx_a;
  logic [IW-1:0]     k_a;
  logic [IW-1:0]     jc_a;
  logic [IW-1:0]     dc_a;
  logic [CW-1:0]     dc_last;
  logic [IW-1:0]     dc_last_a;
  logic [IW-1:0]     rd_addr;
  logic              rd_en;
  logic [IW-1:0]     list_addr;
  logic              list_en;
  logic [TIME_W-1:0] elapsed;
  logic              hit;

  assign idx_a     = IW'(in_idx);
  assign k_a       = k[IW-1:0];
  assign jc_a      = job_count[IW-1:0];
  assign dc_a      = due_count[IW-1:0];
  assign dc_last   = due_count - 1'b1;
  assign dc_last_a = dc_last[IW-1:0];

  assign rd_en     = cmd.scan_rd || cmd.flag_rd || cmd.cpl_rd;
  assign rd_addr   = cmd.flag_rd ? list_q : (cmd.scan_rd ? k_a : idx_a);
  assign list_en   = cmd.list_rd || cmd.last_rd;
  assign list_addr = cmd.list_rd ? k_a : dc_last_a;

  assign elapsed = in_now - last_q;
  assign hit     = flag_q[FLAG_RUN] && !due_mark[k_a] && (elapsed >= ival_q)
                   && (due_count < MAX_CNT);

  // Priority order: first plain priority entry, then last stallable priority
  // entry, then last normal entry, otherwise the head of the list.
  always_comb begin
    if (prio_found) begin
      sel_idx = prio_idx;
      sel_job = prio_job;
    end else if (ps_found) begin
      sel_idx = ps_idx;
      sel_job = ps_job;
    end else if (norm_found) begin
      sel_idx = norm_idx;
      sel_job = norm_job;
    end else begin
      sel_idx = '0;
      sel_job = first_job;
    end
  end

  always_comb begin
    status.mode       = in_mode;
    status.table_full = (job_count >= MAX_CNT);
    status.idx_ok     = (XW'(in_idx) < XW'(job_count));
    status.stalled    = in_stalled;
    status.scan_end   = (k == job_count);
    status.due_empty  = (due_count == '0);
    status.pick_end   = (k == due_count) || prio_found;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      job_count  <= '0;
      due_count  <= '0;
      due_mark   <= '0;
      k          <= '0;
      prio_found <= 1'b0;
      ps_found   <= 1'b0;
      norm_found <= 1'b0;
    end else begin
      if (cmd.reg_write) begin
        job_count      <= job_count + 1'b1;
        due_mark[jc_a] <= 1'b0;
      end
      if (cmd.scan_clr || cmd.pick_clr) begin
        k <= '0;
      end
      if (cmd.scan_eval) begin
        k <= k + 1'b1;
        if (hit) begin
          due_mark[k_a] <= 1'b1;
          due_count     <= due_count + 1'b1;
        end
      end
      if (cmd.pick_clr) begin
        prio_found <= 1'b0;
        ps_found   <= 1'b0;
        norm_found <= 1'b0;
      end
      if (cmd.pick_eval) begin
        k <= k + 1'b1;
        if (flag_q[FLAG_STALL]) begin
          if (flag_q[FLAG_PRIO]) begin
            ps_found <= 1'b1;
          end
        end else if (flag_q[FLAG_PRIO]) begin
          prio_found <= 1'b1;
        end else begin
          norm_found <= 1'b1;
        end
      end
      if (cmd.remove) begin
        due_mark[sel_job] <= 1'b0;
        due_count         <= dc_last;
      end
    end
  end

  // Payload, memories and result registers.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_mode    <= s_tuser[MODE_W-1:0];
      in_now     <= s_tdata[31:0];
      in_idx     <= s_tdata[35:32];
      in_ival    <= s_tdata[67:36];
      in_flags   <= s_tdata[70:68];
      in_stalled <= s_tdata[71];
    end

    if (cmd.reg_write) begin
      ival_mem[jc_a] <= '0;
      flag_mem[jc_a] <= '0;
      last_mem[jc_a] <= in_now;
    end
    if (cmd.upd_write) begin
      ival_mem[idx_a] <= in_ival;
      flag_mem[idx_a] <= in_flags;
    end
    if (cmd.cpl_now) begin
      last_mem[idx_a] <= in_now;
    end
    if (cmd.cpl_add) begin
      last_mem[idx_a] <= last_q + ival_q;
    end

    if (rd_en) begin
      ival_q <= ival_mem[rd_addr];
      last_q <= last_mem[rd_addr];
      flag_q <= flag_mem[rd_addr];
    end

    if (cmd.scan_eval && hit) begin
      list_mem[dc_a] <= k_a;
    end
    if (cmd.remove) begin
      list_mem[sel_idx] <= list_q;
    end
    if (list_en) begin
      list_q <= list_mem[list_addr];
    end

    if (cmd.pick_eval) begin
      if (k == '0) begin
        first_job <= list_q;
      end
      if (flag_q[FLAG_STALL]) begin
        if (flag_q[FLAG_PRIO]) begin
          ps_idx <= k_a;
          ps_job <= list_q;
        end
      end else if (flag_q[FLAG_PRIO]) begin
        prio_idx <= k_a;
        prio_job <= list_q;
      end else begin
        norm_idx <= k_a;
        norm_job <= list_q;
      end
    end

    if (cmd.reg_write) begin
      res_id    <= ID_W'(job_count);
      res_valid <= 1'b1;
      res_err   <= ERR_OK;
    end
    if (cmd.full_err || cmd.idx_err) begin
      res_id    <= '0;
      res_valid <= 1'b0;
      res_err   <= cmd.full_err ? ERR_FULL : ERR_INDEX;
    end
    if (cmd.upd_write || cmd.cpl_now || cmd.cpl_add || cmd.none_due) begin
      res_id    <= '0;
      res_valid <= 1'b0;
      res_err   <= ERR_OK;
    end
    if (cmd.remove) begin
      res_id    <= ID_W'(sel_job);
      res_valid <= 1'b1;
      res_err   <= ERR_OK;
    end

    if (cmd.out_load) begin
      m_tdata <= M_TDATA_W'(res_id);
      m_tuser <= {res_err, res_valid};
    end
  end

`ifndef SYNTHESIS
  a_due_within_jobs: assert property (@(posedge clk) disable iff (rst)
    due_count <= job_count)
    else $error("due list holds more entries than registered jobs");

  a_marks_match_list: assert property (@(posedge clk) disable iff (rst)
    $countones(due_mark) == int'(due_count))
    else $error("due marks disagree with due list length");

  a_jobs_bounded: assert property (@(posedge clk) disable iff (rst)
    job_count <= MAX_CNT)
    else $error("job count exceeds table depth");

  a_remove_nonempty: assert property (@(posedge clk) disable iff (rst)
    cmd.remove |-> (due_count != '0) && due_mark[sel_job])
    else $error("removal from an empty due list or of an unmarked job");
`endif

endmodule

// ===== design/periodic_job_priority_scheduler.sv =====
// Top level of the periodic job scheduler: joins the sequencer and the datapath.
// Depends on pjs_pkg, pjs_ctrl and pjs_datapath.
//
// Usage: each transfer on the s_ channel is one command, chosen by s_tuser
// (register job, update settings, scheduling pass, completion report). Each
// command produces exactly one transfer on the m_ channel carrying a job id,
// a job-valid flag and an error code.
// Register, update and stalled completion are finished in the decode step; an ok
// completion also adds the interval to its stored start time. A scheduling pass
// reads each registered job from the job tables and checks it, then, if any job
// is due, examines due list entries in turn (list read, flag read, compare) until
// a plain priority entry is found or the list ends, and removes the chosen one.
// One command is worked on at a time; the next input is taken as soon as the
// previous result sits in the output register, even if it has not left yet.
// If the receiver stalls, the finished result waits there and the block holds
// its next result until the output register is free.
// Reset clears the job count, the due list length and all due marks; the job
// tables need no clearing, since only registered entries are ever read.
module periodic_job_priority_scheduler #(
  parameter int MAX_JOBS = pjs_pkg::MAX_JOBS_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // now[31:0], job_index[35:32], interval[67:36], running[68], may_stall[69],
  // priority_req[70], stalled[71]
  input  logic [pjs_pkg::S_TDATA_W-1:0] s_tdata,
  // mode[1:0]
  input  logic [pjs_pkg::S_TUSER_W-1:0] s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // job_id[3:0], zero padding[7:4]
  output logic [pjs_pkg::M_TDATA_W-1:0] m_tdata,
  // job_valid[0], error[2:1]
  output logic [pjs_pkg::M_TUSER_W-1:0] m_tuser
);
  import pjs_pkg::*;

  cmd_t    cmd;
  status_t status;

  pjs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  pjs_datapath #(
    .MAX_JOBS (MAX_JOBS)
  ) u_datapath (
    .clk     (clk),
    .rst     (rst),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .cmd     (cmd),
    .status  (status),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser)
  );

endmodule
